/* design/slst_pkg.sv */
`timescale 1ns / 1ps
package slst_pkg;

	localparam int CAPACITY   = 64;
	localparam int VALUE_BITS = 32;
	localparam int POS_W      = 7;
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_GET    = 2'd2,
		CMD_SEARCH = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t   cmd;
		value_t value;
		pos_t   position;
	} req_t;

	typedef struct packed {
		logic   ok;
		value_t value_out;
		pos_t   found_position;
		pos_t   count;
		logic   empty_res;
	} rsp_t;

	// per-cell controls from the top level
	typedef struct packed {
		logic valid;
		logic ins;
		logic del;
	} cell_ctl_t;

	// per-cell compare results
	typedef struct packed {
		logic lt;
		logic eq;
	} cell_flag_t;

endpackage

/* design/sorted_list_engine.sv */
`timescale 1ns / 1ps
// A transaction accepted at an edge is held in the s1 registers; its result is
// then registered into rsp_q from s1 and offered on rsp until it is taken.
// One transaction per cycle while no response is held by rsp_stall; every cell
// compares and shifts in the accept cycle, and the encode/select of the result runs
// in the next cycle. Reset clears the count and the handshake state; cell contents
// are undefined until written and are never read beyond the count.
module sorted_list_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  slst_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output slst_pkg::rsp_t  rsp
);
	import slst_pkg::*;

	cnt_t                count_q;
	logic                s1_valid_q;
	cmd_t                cmd_s1;
	logic                ok_s1;
	logic [CAPACITY-1:0] found_s1;
	logic [CAPACITY-1:0] sel_s1;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	cell_ctl_t           ctl     [CAPACITY];
	cell_flag_t          flags   [CAPACITY];
	value_t              entries [CAPACITY];
	logic [CAPACITY-1:0] left_lt;
	logic [CAPACITY-1:0] found_d;
	logic [CAPACITY-1:0] sel_d;

	logic   accept;
	logic   rsp_load;
	logic   full;
	logic   pos_ok;
	logic   ins_go;
	logic   del_go;
	logic   ok_d;
	pos_t   found_position;
	value_t value_out;

	assign rsp_load  = s1_valid_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = s1_valid_q && !rsp_load;
	assign accept    = req_valid && !req_stall;

	assign full   = (count_q >= CNT_W'(CAPACITY));
	assign pos_ok = (req.position != '0) && (32'(req.position) <= 32'(count_q));
	assign ins_go = accept && (req.cmd == CMD_INSERT) && !full;
	assign del_go = accept && (req.cmd == CMD_DELETE) && pos_ok;

	always_comb begin
		case (req.cmd)
			CMD_INSERT: ok_d = !full;
			CMD_DELETE: ok_d = pos_ok;
			CMD_GET:    ok_d = pos_ok;
			default:    ok_d = 1'b0;
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign left_lt[i] = 1'b1;
		end else begin : g_body
			assign left_lt[i] = flags[i-1].lt;
		end

		assign ctl[i].valid = (32'(count_q) > i);
		assign ctl[i].ins   = ins_go;
		assign ctl[i].del   = del_go && (32'(req.position) <= i + 1);

		assign found_d[i] = (req.cmd == CMD_SEARCH) && flags[i].eq && left_lt[i];
		assign sel_d[i]   = (req.cmd == CMD_GET) && ctl[i].valid
			&& (32'(req.position) == i + 1);

		slst_cell u_cell (
			.clk         (clk),
			.ctl         (ctl[i]),
			.val         (req.value),
			.left_lt     (left_lt[i]),
			.left_entry  (entries[(i == 0) ? 0 : i - 1]),
			.right_entry (entries[(i == CAPACITY - 1) ? i : i + 1]),
			.flags       (flags[i]),
			.entry       (entries[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ins_go) begin
			count_q <= count_q + CNT_W'(1);
		end else if (del_go) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (rsp_load) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= req.cmd;
			ok_s1    <= ok_d;
			found_s1 <= found_d;
			sel_s1   <= sel_d;
		end
	end

	slst_resolve u_resolve (
		.found          (found_s1),
		.sel            (sel_s1),
		.entries        (entries),
		.found_position (found_position),
		.value_out      (value_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// count_q here already reflects the transaction held in s1
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.ok             <= (cmd_s1 == CMD_SEARCH) ? (|found_s1) : ok_s1;
			rsp_q.value_out      <= value_out;
			rsp_q.found_position <= found_position;
			rsp_q.count          <= POS_W'(count_q);
			rsp_q.empty_res      <= (count_q == '0);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= CAPACITY)
		else $error("count exceeds capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ins_go |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow the list");

	a_found_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> ($onehot0(found_s1) && $onehot0(sel_s1)))
		else $error("match or select vector not one-hot");

	a_found_search: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && (|found_s1)) |-> (cmd_s1 == CMD_SEARCH))
		else $error("match reported for a non-search command");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !rsp_load) |-> req_stall)
		else $error("transaction accepted while stage one is blocked");

endmodule

/* design/slst_cell.sv */
`timescale 1ns / 1ps
module slst_cell (
	input  logic                   clk,
	input  slst_pkg::cell_ctl_t    ctl,
	input  slst_pkg::value_t       val,
	input  logic                   left_lt,
	input  slst_pkg::value_t       left_entry,
	input  slst_pkg::value_t       right_entry,
	output slst_pkg::cell_flag_t   flags,
	output slst_pkg::value_t       entry
);
	import slst_pkg::*;

	value_t entry_q;

	assign flags.lt = ctl.valid && (entry_q < val);
	assign flags.eq = ctl.valid && (entry_q == val);
	assign entry    = entry_q;

	// insert: keep if smaller, take the new value at the boundary, else shift right; delete: shift left
	always_ff @(posedge clk) begin
		if (ctl.ins && !flags.lt) begin
			entry_q <= left_lt ? val : left_entry;
		end else if (ctl.del) begin
			entry_q <= right_entry;
		end
	end

endmodule

/* design/slst_resolve.sv */
`timescale 1ns / 1ps
module slst_resolve (
	input  logic [slst_pkg::CAPACITY-1:0] found,
	input  logic [slst_pkg::CAPACITY-1:0] sel,
	input  slst_pkg::value_t              entries [slst_pkg::CAPACITY],
	output slst_pkg::pos_t                found_position,
	output slst_pkg::value_t              value_out
);
	import slst_pkg::*;

	// both vectors are one-hot or zero, so OR-reduction acts as encode and mux
	always_comb begin
		found_position = '0;
		value_out      = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (found[i]) begin
				found_position = found_position | POS_W'(i + 1);
			end
			if (sel[i]) begin
				value_out = value_out | entries[i];
			end
		end
	end

endmodule
